### rtl/core/pats_pkg.sv
// pats_pkg: shared widths, codes and structs of the priority aging task scheduler
// no dependencies; imported by the top, the controller, the cells, the checker and the bench
package pats_pkg;

   localparam int SLOT_W  = 4;
   localparam int PRIO_W  = 6;
   localparam int QPOS_W  = 4;
   localparam int COUNT_W = 5;
   localparam int STEP_W  = 4;
   localparam int QUANT_W = 8;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 2;
   localparam int DATA_W  = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 3'd0,
      CMD_SET      = 3'd1,
      CMD_DISPATCH = 3'd2,
      CMD_TICK     = 3'd3,
      CMD_YIELD    = 3'd4,
      CMD_FINISH   = 3'd5
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_REFUSED = 2'd2
   } status_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_HIGH  = 2'd0,
      CSR_LOW   = 2'd1,
      CSR_STEP  = 2'd2,
      CSR_QUANT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                     have;
      logic signed [PRIO_W-1:0] dyn;
      logic signed [PRIO_W-1:0] stat;
      logic [QPOS_W-1:0]        qpos;
      logic [SLOT_W-1:0]        idx;
   } best_type;

   typedef struct packed {
      logic                     wr_prio;
      logic                     enq;
      logic                     disp;
      logic [SLOT_W-1:0]        slot;
      logic signed [PRIO_W-1:0] prio;
      logic [QPOS_W-1:0]        enq_pos;
      logic [SLOT_W-1:0]        win_slot;
      logic [QPOS_W-1:0]        win_qpos;
      logic signed [PRIO_W-1:0] high;
      logic [STEP_W-1:0]        step;
   } cell_op_type;

   typedef struct packed {
      best_type                 best;
      logic                     slot_ready;
      logic signed [PRIO_W-1:0] slot_static;
   } row_status_type;

endpackage

### rtl/core/priority_aging_task_scheduler_unit.sv
// Priority task scheduler with aging over SLOTS task slots, one result beat per request beat.
// A request beat is taken only while the block is idle; the result sits in an output register,
// so the next request is taken while a finished result still waits. Add, set priority, tick,
// yield and finish pass through accept and execute. Dispatch passes through accept, a scan in
// which the best candidate ripples down the row of slot cells one cell per cycle, and execute,
// where the winner commits and the other ready slots above the high bound age together. Lower
// priority values are more urgent. Configuration writes are taken in any cycle (csr_ready
// is always high) and must only be issued while no request is in flight.
// Depends on pats_pkg, pats_ctrl and pats_cell.
module priority_aging_task_scheduler_unit
   import pats_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [SLOT_W-1:0]        req_task_slot,
   input  logic signed [PRIO_W-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]        rsp_chosen_slot,
   output logic                     rsp_preempted,
   output logic                     rsp_running_valid,
   output logic [SLOT_W-1:0]        rsp_running_slot,
   output logic signed [PRIO_W-1:0] rsp_slot_priority,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   cell_op_type              op;
   row_status_type           row;
   logic [SLOT_W-1:0]        rd_slot;
   best_type                 best_w   [SLOTS+1];
   logic                     ready_w  [SLOTS];
   logic signed [PRIO_W-1:0] static_w [SLOTS];

   pats_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_task_slot     (req_task_slot),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_chosen_slot   (rsp_chosen_slot),
      .rsp_preempted     (rsp_preempted),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_slot  (rsp_running_slot),
      .rsp_slot_priority (rsp_slot_priority),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rd_slot           (rd_slot),
      .op                (op),
      .row               (row)
   );

   assign best_w[0] = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      pats_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .best_in    (best_w[g]),
         .best_out   (best_w[g+1]),
         .ready_out  (ready_w[g]),
         .static_out (static_w[g])
      );
   end

   // readback of the addressed slot
   always_comb begin
      row.best        = best_w[SLOTS];
      row.slot_ready  = 1'b0;
      row.slot_static = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if ((i < (1 << SLOT_W)) && (rd_slot == SLOT_W'(i))) begin
            row.slot_ready  = ready_w[i];
            row.slot_static = static_w[i];
         end
      end
   end

endmodule

### rtl/core/pats_cell.sv
// pats_cell: one task slot of the scheduler row, its priorities, ready flag and queue place
// passes the best candidate so far to its right neighbor; uses pats_pkg
module pats_cell
   import pats_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_op_type              op,
   input  best_type                 best_in,
   output best_type                 best_out,
   output logic                     ready_out,
   output logic signed [PRIO_W-1:0] static_out
);

   localparam bit REACHABLE = INDEX < (1 << SLOT_W);

   logic signed [PRIO_W-1:0] stat_ff;
   logic signed [PRIO_W-1:0] dyn_ff;
   logic                     ready_ff;
   logic [QPOS_W-1:0]        qpos_ff;
   best_type                 best_ff;
   best_type                 best_in_w;

   logic                     is_slot;
   logic                     is_win;
   logic signed [PRIO_W+1:0] aged_w;
   logic signed [PRIO_W+1:0] high_w;
   logic signed [PRIO_W-1:0] aged_sat;
   logic                     better;

   assign is_slot = REACHABLE && (op.slot == SLOT_W'(INDEX));
   assign is_win  = REACHABLE && (op.win_slot == SLOT_W'(INDEX));

   assign aged_w = {{2{dyn_ff[PRIO_W-1]}}, dyn_ff} - {{(PRIO_W+2-STEP_W){1'b0}}, op.step};
   assign high_w = {{2{op.high[PRIO_W-1]}}, op.high};
   assign aged_sat = (aged_w < high_w) ? op.high : aged_w[PRIO_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff  <= '0;
         dyn_ff   <= '0;
         ready_ff <= 1'b0;
      end else begin
         if (op.wr_prio && is_slot) begin
            stat_ff <= op.prio;
            dyn_ff  <= op.prio;
         end
         if (op.enq && is_slot) begin
            ready_ff <= 1'b1;
         end
         if (op.disp && ready_ff) begin
            if (is_win) begin
               dyn_ff   <= stat_ff;
               ready_ff <= 1'b0;
            end else if (dyn_ff > op.high) begin
               dyn_ff <= aged_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op.enq && is_slot) begin
         qpos_ff <= op.enq_pos;
      end else if (op.disp && ready_ff && !is_win && (qpos_ff > op.win_qpos)) begin
         qpos_ff <= qpos_ff - QPOS_W'(1);
      end
   end

   // candidate compare: dynamic, then static, then queue order
   assign best_in_w = best_in;
   always_comb begin
      better = 1'b0;
      if (ready_ff) begin
         if (!best_in_w.have) begin
            better = 1'b1;
         end else if (dyn_ff < best_in_w.dyn) begin
            better = 1'b1;
         end else if (dyn_ff == best_in_w.dyn) begin
            if (stat_ff < best_in_w.stat) begin
               better = 1'b1;
            end else if ((stat_ff == best_in_w.stat) && (qpos_ff < best_in_w.qpos)) begin
               better = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else if (better) begin
         best_ff.have <= 1'b1;
         best_ff.dyn  <= dyn_ff;
         best_ff.stat <= stat_ff;
         best_ff.qpos <= qpos_ff;
         best_ff.idx  <= SLOT_W'(INDEX);
      end else begin
         best_ff <= best_in_w;
      end
   end

   assign best_out   = best_ff;
   assign ready_out  = ready_ff;
   assign static_out = stat_ff;

endmodule

### rtl/core/pats_ctrl.sv
// pats_ctrl: command sequencer, configuration registers, running task state and result register
// drives the broadcast operation of the cell row; uses pats_pkg
module pats_ctrl
   import pats_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [SLOT_W-1:0]        req_task_slot,
   input  logic signed [PRIO_W-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]        rsp_chosen_slot,
   output logic                     rsp_preempted,
   output logic                     rsp_running_valid,
   output logic [SLOT_W-1:0]        rsp_running_slot,
   output logic signed [PRIO_W-1:0] rsp_slot_priority,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   output logic [SLOT_W-1:0]        rd_slot,
   output cell_op_type              op,
   input  row_status_type           row
);

   localparam int CNT_W = $clog2(SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic [CMD_W-1:0]         cmd_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [PRIO_W-1:0] prio_ff;

   logic signed [PRIO_W-1:0] high_ff;
   logic signed [PRIO_W-1:0] low_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [QUANT_W-1:0]       quant_ff;

   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     rv_ff, rv_in;
   logic [SLOT_W-1:0]        rt_ff, rt_in;
   logic [QUANT_W-1:0]       ql_ff, ql_in;

   logic                     rsp_valid_ff;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [SLOT_W-1:0]        chosen_ff, chosen_in;
   logic                     preempt_ff, preempt_in;
   logic signed [PRIO_W-1:0] readback_ff, readback_in;

   logic                     out_free;
   logic                     fire;
   logic                     in_range;
   logic signed [PRIO_W-1:0] clamped;
   logic [QUANT_W-1:0]       ql_dec;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_EXEC) && out_free;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign in_range  = 32'(slot_ff) < SLOTS;
   assign rd_slot   = slot_ff;
   assign clamped   = (prio_ff < high_ff) ? high_ff :
                      (prio_ff > low_ff)  ? low_ff  : prio_ff;
   assign ql_dec    = (ql_ff != '0) ? ql_ff - QUANT_W'(1) : '0;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = (req_command == CMD_DISPATCH) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SLOTS - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      op          = '0;
      op.slot     = slot_ff;
      op.prio     = clamped;
      op.enq_pos  = count_ff[QPOS_W-1:0];
      op.win_slot = row.best.idx;
      op.win_qpos = row.best.qpos;
      op.high     = high_ff;
      op.step     = step_ff;
      count_in    = count_ff;
      rv_in       = rv_ff;
      rt_in       = rt_ff;
      ql_in       = ql_ff;
      status_in   = STAT_DONE;
      chosen_in   = '0;
      preempt_in  = 1'b0;
      readback_in = in_range ? row.slot_static : '0;
      if (fire) begin
         case (cmd_ff)
            CMD_ADD: begin
               if (!in_range || row.slot_ready || (rv_ff && (rt_ff == slot_ff))) begin
                  status_in = STAT_REFUSED;
               end else begin
                  op.wr_prio  = 1'b1;
                  op.enq      = 1'b1;
                  count_in    = count_ff + COUNT_W'(1);
                  readback_in = clamped;
               end
            end
            CMD_SET: begin
               if (!in_range) begin
                  status_in = STAT_REFUSED;
               end else begin
                  op.wr_prio  = 1'b1;
                  readback_in = clamped;
               end
            end
            CMD_DISPATCH: begin
               if (rv_ff) begin
                  status_in = STAT_REFUSED;
               end else if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  op.disp   = 1'b1;
                  count_in  = count_ff - COUNT_W'(1);
                  rv_in     = 1'b1;
                  rt_in     = row.best.idx;
                  ql_in     = quant_ff;
                  chosen_in = row.best.idx;
               end
            end
            CMD_TICK: begin
               if (rv_ff) begin
                  ql_in = ql_dec;
                  if (ql_dec == '0) begin
                     op.enq     = 1'b1;
                     op.slot    = rt_ff;
                     count_in   = count_ff + COUNT_W'(1);
                     rv_in      = 1'b0;
                     rt_in      = '0;
                     preempt_in = 1'b1;
                  end
               end
            end
            CMD_YIELD, CMD_FINISH: begin
               if (!rv_ff) begin
                  status_in = STAT_EMPTY;
               end else begin
                  if (cmd_ff == CMD_YIELD) begin
                     op.enq   = 1'b1;
                     op.slot  = rt_ff;
                     count_in = count_ff + COUNT_W'(1);
                  end
                  rv_in = 1'b0;
                  rt_in = '0;
                  ql_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         rt_ff        <= '0;
         ql_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         rt_ff    <= rt_in;
         ql_ff    <= ql_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= -6'sd20;
         low_ff   <= 6'sd20;
         step_ff  <= 4'd1;
         quant_ff <= 8'd20;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HIGH:  high_ff  <= csr_data[PRIO_W-1:0];
            CSR_LOW:   low_ff   <= csr_data[PRIO_W-1:0];
            CSR_STEP:  step_ff  <= csr_data[STEP_W-1:0];
            CSR_QUANT: quant_ff <= csr_data[QUANT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         cmd_ff  <= req_command;
         slot_ff <= req_task_slot;
         prio_ff <= req_priority_req;
      end
      if (fire) begin
         status_ff   <= status_in;
         chosen_ff   <= chosen_in;
         preempt_ff  <= preempt_in;
         readback_ff <= readback_in;
      end
   end

   // running state in the result register is the committed state after the beat
   logic                     run_valid_ff;
   logic [SLOT_W-1:0]        run_slot_ff;
   always_ff @(posedge clock) begin
      if (fire) begin
         run_valid_ff <= rv_in;
         run_slot_ff  <= rv_in ? rt_in : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_chosen_slot   = chosen_ff;
   assign rsp_preempted     = preempt_ff;
   assign rsp_running_valid = run_valid_ff;
   assign rsp_running_slot  = run_slot_ff;
   assign rsp_slot_priority = readback_ff;

endmodule

### rtl/core/pats_checker.sv
// pats_checker: port-level assertions on the scheduler result channel
// bound to priority_aging_task_scheduler_unit; uses pats_pkg
module pats_checker
   import pats_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [STAT_W-1:0]        rsp_status,
   input logic [SLOT_W-1:0]        rsp_chosen_slot,
   input logic                     rsp_preempted,
   input logic                     rsp_running_valid,
   input logic [SLOT_W-1:0]        rsp_running_slot,
   input logic signed [PRIO_W-1:0] rsp_slot_priority
);

   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running_valid) |-> (rsp_running_slot == '0))
      else $error("running slot nonzero with nothing running");

   a_preempt_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_preempted) |-> (!rsp_running_valid && (rsp_status == STAT_DONE)))
      else $error("preempt beat still shows a running task");

   a_chosen_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_chosen_slot != '0)) |->
         (rsp_running_valid && (rsp_running_slot == rsp_chosen_slot)))
      else $error("dispatched slot is not the running slot");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_running_slot) && $stable(rsp_slot_priority)))
      else $error("stalled result beat changed");

endmodule

bind priority_aging_task_scheduler_unit pats_checker u_pats_checker (.*);

### bench/priority_aging_task_scheduler_unit_test.sv
`timescale 1ns / 100ps
// priority_aging_task_scheduler_unit_test: self-checking bench for the priority aging scheduler
// directed table then random command phases, every result beat checked against a table value or a predictor
// depends on pats_pkg and priority_aging_task_scheduler_unit
module priority_aging_task_scheduler_unit_test;
   import pats_pkg::*;

   localparam int SLOT_COUNT = 16;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 190;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = {1'b1, {(PRIO_W-1){1'b0}}};
   localparam logic signed [PRIO_W-1:0] PRIO_CEIL = {1'b0, {(PRIO_W-1){1'b1}}};

   typedef struct packed {
      status_type               status;
      logic [SLOT_W-1:0]        chosen_slot;
      logic                     preempted;
      logic                     running_valid;
      logic [SLOT_W-1:0]        running_slot;
      logic signed [PRIO_W-1:0] slot_priority;
   } sched_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [SLOT_W-1:0]        slot;
      logic signed [PRIO_W-1:0] prio;
      logic                     has_want;
      sched_result_type         want;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command = CMD_ADD;
   logic [SLOT_W-1:0]        req_task_slot = '0;
   logic signed [PRIO_W-1:0] req_priority_req = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic [SLOT_W-1:0]        rsp_chosen_slot;
   logic                     rsp_preempted;
   logic                     rsp_running_valid;
   logic [SLOT_W-1:0]        rsp_running_slot;
   logic signed [PRIO_W-1:0] rsp_slot_priority;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_W-1:0]         csr_index = CSR_HIGH;
   logic [DATA_W-1:0]        csr_data = '0;

   // scheduler state as predicted
   int stat_prio [SLOT_COUNT];
   int dyn_prio [SLOT_COUNT];
   bit slot_ready [SLOT_COUNT];
   int queue_pos [SLOT_COUNT];
   int ready_total = 0;
   bit running_flag = 1'b0;
   int running_id = 0;
   int quantum_left = 0;
   int bound_high = -20;
   int bound_low = 20;
   int aging_step = 1;
   int quantum_ticks = 20;

   sched_result_type pending_outcomes [$];
   directed_row_type directed_rows [$];
   sched_result_type head;
   int fail_count = 0;
   int burst_left = 1;
   int stall_mode = 0;
   int stall_span = 0;

   always #5 clock = ~clock;

   priority_aging_task_scheduler_unit #(.SLOTS(SLOT_COUNT)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_task_slot     (req_task_slot),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_chosen_slot   (rsp_chosen_slot),
      .rsp_preempted     (rsp_preempted),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_slot  (rsp_running_slot),
      .rsp_slot_priority (rsp_slot_priority),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   function automatic int clamp_to_bounds(input int p);
      if (p < bound_high) return bound_high;
      if (p > bound_low) return bound_low;
      return p;
   endfunction

   function automatic void join_ready(input int s);
      slot_ready[s] = 1'b1;
      queue_pos[s] = ready_total;
      ready_total++;
   endfunction

   function automatic sched_result_type advance_scheduler(input logic [CMD_W-1:0] cmd,
         input logic [SLOT_W-1:0] slot, input logic signed [PRIO_W-1:0] prio_in);
      sched_result_type r;
      int s, p, best, d, i;
      bit have;
      r = '0;
      s = int'(slot);
      case (cmd)
         CMD_ADD: begin
            if (slot_ready[s] || (running_flag && running_id == s)) begin
               r.status = STAT_REFUSED;
            end else begin
               p = clamp_to_bounds(int'(prio_in));
               stat_prio[s] = p;
               dyn_prio[s] = p;
               join_ready(s);
            end
         end
         CMD_SET: begin
            p = clamp_to_bounds(int'(prio_in));
            stat_prio[s] = p;
            dyn_prio[s] = p;
         end
         CMD_DISPATCH: begin
            if (running_flag) begin
               r.status = STAT_REFUSED;
            end else if (ready_total == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               have = 1'b0;
               best = 0;
               for (i = 0; i < SLOT_COUNT; i++) begin
                  if (slot_ready[i] && (!have || dyn_prio[i] < dyn_prio[best] ||
                        (dyn_prio[i] == dyn_prio[best] && (stat_prio[i] < stat_prio[best] ||
                        (stat_prio[i] == stat_prio[best] && queue_pos[i] < queue_pos[best])))))
                  begin
                     best = i;
                     have = 1'b1;
                  end
               end
               // waiting tasks age toward the most urgent bound
               for (i = 0; i < SLOT_COUNT; i++) begin
                  if (slot_ready[i] && i != best && dyn_prio[i] > bound_high) begin
                     d = dyn_prio[i] - aging_step;
                     dyn_prio[i] = (d < bound_high) ? bound_high : d;
                  end
               end
               dyn_prio[best] = stat_prio[best];
               for (i = 0; i < SLOT_COUNT; i++) begin
                  if (slot_ready[i] && queue_pos[i] > queue_pos[best]) queue_pos[i]--;
               end
               slot_ready[best] = 1'b0;
               ready_total--;
               running_flag = 1'b1;
               running_id = best;
               quantum_left = quantum_ticks;
               r.chosen_slot = best[SLOT_W-1:0];
            end
         end
         CMD_TICK: begin
            if (running_flag) begin
               if (quantum_left > 0) quantum_left--;
               if (quantum_left == 0) begin
                  join_ready(running_id);
                  running_flag = 1'b0;
                  running_id = 0;
                  r.preempted = 1'b1;
               end
            end
         end
         CMD_YIELD, CMD_FINISH: begin
            if (!running_flag) begin
               r.status = STAT_EMPTY;
            end else begin
               if (cmd == CMD_YIELD) join_ready(running_id);
               running_flag = 1'b0;
               running_id = 0;
               quantum_left = 0;
            end
         end
         default: ;
      endcase
      r.running_valid = running_flag;
      r.running_slot = running_flag ? running_id[SLOT_W-1:0] : '0;
      r.slot_priority = stat_prio[s][PRIO_W-1:0];
      return r;
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] cmd, input int slot, input int prio,
         input logic has_want, input status_type st, input int chosen, input int pre,
         input int rv, input int rs, input int sp);
      directed_row_type row;
      row.cmd = cmd;
      row.slot = slot[SLOT_W-1:0];
      row.prio = prio[PRIO_W-1:0];
      row.has_want = has_want;
      row.want.status = st;
      row.want.chosen_slot = chosen[SLOT_W-1:0];
      row.want.preempted = pre[0];
      row.want.running_valid = rv[0];
      row.want.running_slot = rs[SLOT_W-1:0];
      row.want.slot_priority = sp[PRIO_W-1:0];
      directed_rows.push_back(row);
   endtask

   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
         input logic signed [PRIO_W-1:0] prio, input logic has_want,
         input sched_result_type want);
      sched_result_type outcome;
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_task_slot <= slot;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      outcome = advance_scheduler(cmd, slot, prio);
      pending_outcomes.push_back(has_want ? want : outcome);
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HIGH:  bound_high = int'($signed(data[PRIO_W-1:0]));
         CSR_LOW:   bound_low = int'($signed(data[PRIO_W-1:0]));
         CSR_STEP:  aging_step = int'(data[STEP_W-1:0]);
         CSR_QUANT: quantum_ticks = int'(data[QUANT_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int high, input int low, input int step, input int quant);
      logic [DATA_W-1:0] d;
      // unused upper bits carry noise
      d = DATA_W'($urandom);
      d[PRIO_W-1:0] = high[PRIO_W-1:0];
      write_register(CSR_HIGH, d);
      d = DATA_W'($urandom);
      d[PRIO_W-1:0] = low[PRIO_W-1:0];
      write_register(CSR_LOW, d);
      d = DATA_W'($urandom);
      d[STEP_W-1:0] = step[STEP_W-1:0];
      write_register(CSR_STEP, d);
      write_register(CSR_QUANT, quant[QUANT_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic signed [7:0] want,
         input logic signed [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result beat with nothing pending, status %0d actual slot %0d",
               $time, rsp_status, rsp_chosen_slot);
            fail_count++;
         end else begin
            head = pending_outcomes.pop_front();
            check_field("status", 8'(head.status), 8'(rsp_status));
            check_field("chosen_slot", 8'(head.chosen_slot), 8'(rsp_chosen_slot));
            check_field("preempted", 8'(head.preempted), 8'(rsp_preempted));
            check_field("running_valid", 8'(head.running_valid), 8'(rsp_running_valid));
            check_field("running_slot", 8'(head.running_slot), 8'(rsp_running_slot));
            check_field("slot_priority", 8'(head.slot_priority), 8'(rsp_slot_priority));
         end
      end
   end

   // receiver back-pressure in random modes: none, random stalls or a periodic pattern
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_span = $urandom_range(16, 96);
      end
      stall_span = stall_span - 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 4);
         default: rsp_stall <= ((stall_span % 7) < 3);
      endcase
   end

   initial begin
      directed_row_type row;
      int i, ph, n, roll;
      logic [CMD_W-1:0] cmd;
      logic signed [PRIO_W-1:0] prio;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(CMD_DISPATCH, 0, 0, 1'b1, STAT_EMPTY, 0, 0, 0, 0, 0);
      add_row(CMD_YIELD, 0, 0, 1'b1, STAT_EMPTY, 0, 0, 0, 0, 0);
      add_row(CMD_FINISH, 15, 0, 1'b1, STAT_EMPTY, 0, 0, 0, 0, 0);
      add_row(CMD_TICK, 0, 0, 1'b1, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_ADD, 0, int'(PRIO_FLOOR), 1'b1, STAT_DONE, 0, 0, 0, 0, -20);
      add_row(CMD_ADD, 15, int'(PRIO_CEIL), 1'b1, STAT_DONE, 0, 0, 0, 0, 20);
      add_row(CMD_SET, 5, int'(PRIO_CEIL), 1'b1, STAT_DONE, 0, 0, 0, 0, 20);
      add_row(CMD_SET, 5, int'(PRIO_FLOOR), 1'b1, STAT_DONE, 0, 0, 0, 0, -20);
      add_row(CMD_ADD, 0, 5, 1'b1, STAT_REFUSED, 0, 0, 0, 0, -20);
      add_row(CMD_ADD, 7, -20, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_ADD, 3, 20, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_SET, 3, -21, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_DISPATCH, 0, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_ADD, 0, 0, 1'b1, STAT_REFUSED, 0, 0, 1, 0, -20);
      add_row(CMD_DISPATCH, 3, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_SET, 0, 10, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_TICK, 0, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_YIELD, 0, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_DISPATCH, 15, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_TICK, 15, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_FINISH, 15, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_SPARE_LO, 9, -1, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_SPARE_HI, 15, 31, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_DISPATCH, 7, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      add_row(CMD_YIELD, 7, 0, 1'b0, STAT_DONE, 0, 0, 0, 0, 0);
      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         issue_command(row.cmd, row.slot, row.prio, row.has_want, row.want);
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         case (ph)
            0: apply_setting(-32, 31, 15, 0);
            1: apply_setting(31, -32, 0, 255);
            2: apply_setting(-32, 31, 1, 1);
            3: apply_setting(0, 0, 15, 2);
            4: apply_setting(-20, 20, 1, 20);
            default: apply_setting(int'($urandom_range(0, 32)) - 32, $urandom_range(0, 31),
               $urandom_range(0, 15), $urandom_range(1, 12));
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) cmd = CMD_ADD;
            else if (roll < 28) cmd = CMD_SET;
            else if (roll < 50) cmd = CMD_DISPATCH;
            else if (roll < 72) cmd = CMD_TICK;
            else if (roll < 80) cmd = CMD_YIELD;
            else if (roll < 94) cmd = CMD_FINISH;
            else if (roll < 97) cmd = CMD_SPARE_LO;
            else cmd = CMD_SPARE_HI;
            prio = PRIO_W'($urandom);
            issue_command(cmd, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)), prio, 1'b0, '0);
         end
      end

      settle();
      repeat (2 * (SLOT_COUNT + 2)) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
